@@ rtl/smv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_pkg
// Shared constants and types for the selectable-weight matrix-vector block.
// ----------------------------------------------------------------------------
package smv_pkg;

  // default sizes handed to the top level
  localparam int DEF_MAX_COEFFS = 1024;
  localparam int DEF_MAX_ROWS   = 1024;
  localparam int DEF_VALUE_BITS = 16;

  // fixed field widths
  localparam int ACC_BITS   = 48;
  localparam int CFG_BITS   = 11;
  localparam int INDEX_BITS = 10;
  // wide enough for a clamped count up to 65536
  localparam int COUNT_BITS = 17;

  // queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QCOUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  // item modes
  localparam logic [1:0] MODE_LOAD_OTHER = 2'd0;
  localparam logic [1:0] MODE_LOAD_SAME  = 2'd1;
  localparam logic [1:0] MODE_FEATURE    = 2'd2;

  // configuration register indexes
  localparam logic REG_COEFF_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT   = 1'b1;

  localparam logic [CFG_BITS-1:0] COEFF_COUNT_RESET = 11'd1024;
  localparam logic [CFG_BITS-1:0] ROW_COUNT_RESET   = 11'd1;

  // sample position (mod 3) that may pick the same-class weights
  localparam logic [1:0] SAME_PHASE = 2'd2;

  // per-element control carried from front to back
  typedef struct packed {
    logic row_end;
    logic last;
  } row_ctl_t;

endpackage

@@ rtl/smv_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/smv_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_queue
// Short register queue that decouples the front from the multiply back end.
// ----------------------------------------------------------------------------
module smv_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/smv_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_front
// Accepts items, loads weights, tracks row and sample position, picks the
// weight set and reads the weight for each feature into the queue.
// ----------------------------------------------------------------------------
module smv_front import smv_pkg::*; #(
  parameter int MAX_COEFFS = DEF_MAX_COEFFS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [CFG_BITS-1:0]                 cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic [INDEX_BITS-1:0]               weight_index,
  input  logic signed [VALUE_BITS-1:0]        value,
  input  logic                                class_flag,
  input  logic                                batch_start,
  input  logic [QCOUNT_BITS-1:0]              q_count,
  output logic                                q_push,
  output logic [2*VALUE_BITS+$bits(row_ctl_t)-1:0] q_data
);

  localparam int AW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [CFG_BITS-1:0]   coeff_count;
  logic [CFG_BITS-1:0]   row_count;
  logic [AW-1:0]         column_position;
  logic [RW-1:0]         row_position;
  logic [1:0]            sample_phase;
  logic                  use_same;

  logic                  s2_valid;
  logic                  s2_sel;
  logic [VALUE_BITS-1:0] s2_value;
  row_ctl_t              s2_ctl;

  logic                  accept;
  logic                  feat_go;
  logic                  first_feat;
  logic [1:0]            pos;
  logic                  sel_first;
  logic                  sel;
  logic [COUNT_BITS-1:0] ncoef;
  logic [COUNT_BITS-1:0] nrows;
  logic                  row_end;
  logic                  last;
  logic                  idx_ok;
  logic [AW+INDEX_BITS-1:0] idx_wide;
  logic [AW-1:0]         waddr;
  logic                  we_other;
  logic                  we_same;
  logic [VALUE_BITS-1:0] rd_other;
  logic [VALUE_BITS-1:0] rd_same;

  // credit check: the item in the read stage still needs a queue slot
  assign in_stall = ((QCOUNT_BITS+1)'(q_count) + (QCOUNT_BITS+1)'(s2_valid))
                    >= (QCOUNT_BITS+1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;
  assign feat_go  = accept && (mode == MODE_FEATURE);

  // effective counts: zero acts as one, large values saturate
  always_comb begin
    if (coeff_count == '0) begin
      ncoef = COUNT_BITS'(1);
    end else if (COUNT_BITS'(coeff_count) > COUNT_BITS'(MAX_COEFFS)) begin
      ncoef = COUNT_BITS'(MAX_COEFFS);
    end else begin
      ncoef = COUNT_BITS'(coeff_count);
    end
    if (row_count == '0) begin
      nrows = COUNT_BITS'(1);
    end else if (COUNT_BITS'(row_count) > COUNT_BITS'(MAX_ROWS)) begin
      nrows = COUNT_BITS'(MAX_ROWS);
    end else begin
      nrows = COUNT_BITS'(row_count);
    end
  end

  // position and weight-set selection
  assign first_feat = (column_position == '0) && (row_position == '0);
  assign pos        = batch_start ? 2'd0 : sample_phase;
  assign sel_first  = class_flag && (pos == SAME_PHASE);
  assign sel        = first_feat ? sel_first : use_same;
  assign row_end    = (COUNT_BITS'(column_position) + COUNT_BITS'(1)) >= ncoef;
  assign last       = (COUNT_BITS'(row_position) + COUNT_BITS'(1)) >= nrows;

  // weight load decode
  assign idx_ok   = COUNT_BITS'(weight_index) < COUNT_BITS'(MAX_COEFFS);
  assign idx_wide = (AW+INDEX_BITS)'(weight_index);
  assign waddr    = idx_wide[AW-1:0];

  always_comb begin
    we_other = 1'b0;
    we_same  = 1'b0;
    case (mode)
      MODE_LOAD_OTHER: we_other = accept && idx_ok;
      MODE_LOAD_SAME:  we_same  = accept && idx_ok;
      default: ;
    endcase
  end

  // weight stores
  smv_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_COEFFS)
  ) u_other_ram (
    .clk  (clk),
    .we   (we_other),
    .waddr(waddr),
    .wdata(value),
    .re   (feat_go),
    .raddr(column_position),
    .rdata(rd_other)
  );

  smv_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_COEFFS)
  ) u_same_ram (
    .clk  (clk),
    .we   (we_same),
    .waddr(waddr),
    .wdata(value),
    .re   (feat_go),
    .raddr(column_position),
    .rdata(rd_same)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_count <= COEFF_COUNT_RESET;
      row_count   <= ROW_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEFF_COUNT: coeff_count <= cfg_data;
        REG_ROW_COUNT:   row_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // row, column and sample tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      sample_phase    <= '0;
      use_same        <= 1'b0;
      s2_valid        <= 1'b0;
    end else begin
      s2_valid <= feat_go;
      if (feat_go) begin
        if (first_feat) begin
          use_same     <= sel_first;
          sample_phase <= (pos == SAME_PHASE) ? 2'd0 : pos + 2'd1;
        end
        if (row_end) begin
          column_position <= '0;
          row_position    <= last ? '0 : row_position + 1'b1;
        end else begin
          column_position <= column_position + 1'b1;
        end
      end
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (feat_go) begin
      s2_value       <= value;
      s2_sel         <= sel;
      s2_ctl.row_end <= row_end;
      s2_ctl.last    <= last;
    end
  end

  // push the feature with its weight once the read data is back
  assign q_push = s2_valid;
  assign q_data = {s2_ctl, s2_value, s2_sel ? rd_same : rd_other};

endmodule

@@ rtl/smv_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_back
// Multiplies each queued feature by its weight, accumulates a row and holds
// the finished row sum in the output register.
// ----------------------------------------------------------------------------
module smv_back import smv_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     q_empty,
  input  logic [2*VALUE_BITS+$bits(row_ctl_t)-1:0] q_data,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [ACC_BITS-1:0]               row_sum,
  output logic                                     last_row
);

  localparam int PW = 2 * VALUE_BITS;

  row_ctl_t                   q_ctl;
  logic signed [VALUE_BITS-1:0] q_value;
  logic signed [VALUE_BITS-1:0] q_weight;
  logic signed [PW-1:0]       prod;

  logic                       p_valid;
  logic signed [ACC_BITS-1:0] p_prod;
  row_ctl_t                   p_ctl;
  logic signed [ACC_BITS-1:0] accumulator;
  logic signed [ACC_BITS-1:0] sum;

  logic out_free;
  logic acc_go;
  logic p_ready;

  // unpack the queue head
  assign q_ctl    = row_ctl_t'(q_data[PW +: $bits(row_ctl_t)]);
  assign q_value  = q_data[VALUE_BITS +: VALUE_BITS];
  assign q_weight = q_data[VALUE_BITS-1:0];
  assign prod     = q_value * q_weight;

  // flow control through product and accumulate stages
  assign out_free = !out_valid || !out_stall;
  assign acc_go   = p_valid && (!p_ctl.row_end || out_free);
  assign p_ready  = !p_valid || acc_go;
  assign q_pop    = !q_empty && p_ready;
  assign sum      = accumulator + p_prod;

  // control and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid     <= 1'b0;
      out_valid   <= 1'b0;
      accumulator <= '0;
    end else begin
      if (p_ready) begin
        p_valid <= q_pop;
      end
      if (acc_go) begin
        accumulator <= p_ctl.row_end ? '0 : sum;
      end
      if (acc_go && p_ctl.row_end) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // product register and output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_prod <= ACC_BITS'(prod);
      p_ctl  <= q_ctl;
    end
    if (acc_go && p_ctl.row_end) begin
      row_sum  <= sum;
      last_row <= p_ctl.last;
    end
  end

endmodule

@@ rtl/selectable_weight_matvec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selectable_weight_matvec
// Matrix-vector multiply with two selectable Q1.15 weight vectors.
// ----------------------------------------------------------------------------
// Takes one item per clock with no bubbles while the input is not stalled:
// weight loads write a local RAM in the cycle they are accepted, and feature
// items stream through a RAM read stage, a four-entry queue, a registered
// 16x16 multiply and a 48-bit accumulate. A row sum goes from the read stage
// through the queue and the product register to the output register, where
// it is held while stalled. The input stalls only when the queue and read
// stage have no room, which happens only under output back-pressure. Load
// items see every earlier load, so a feature may follow its weight load in
// the very next cycle. No clearing pass is needed after reset.
module selectable_weight_matvec import smv_pkg::*; #(
  parameter int MAX_COEFFS = DEF_MAX_COEFFS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic [INDEX_BITS-1:0]        weight_index,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         class_flag,
  input  logic                         batch_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ACC_BITS-1:0]   row_sum,
  output logic                         last_row
);

  localparam int QW = 2 * VALUE_BITS + $bits(row_ctl_t);

  logic                   q_push;
  logic [QW-1:0]          q_push_data;
  logic                   q_pop;
  logic [QW-1:0]          q_pop_data;
  logic                   q_empty;
  logic [QCOUNT_BITS-1:0] q_count;

  // front: accept, classify, read weights
  smv_front #(
    .MAX_COEFFS(MAX_COEFFS),
    .MAX_ROWS  (MAX_ROWS),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .weight_index(weight_index),
    .value       (value),
    .class_flag  (class_flag),
    .batch_start (batch_start),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  // decoupling queue
  smv_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .empty    (q_empty),
    .count    (q_count)
  );

  // back: multiply, accumulate, output register
  smv_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_pop_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .row_sum  (row_sum),
    .last_row (last_row)
  );

`ifndef SYNTHESIS
  // queue never holds more than its depth
  assert property (@(posedge clk) disable iff (rst)
    q_count <= QCOUNT_BITS'(QUEUE_DEPTH))
    else $error("queue overfilled");

  // a full queue always back-pressures the input
  assert property (@(posedge clk) disable iff (rst)
    q_count == QCOUNT_BITS'(QUEUE_DEPTH) |-> in_stall)
    else $error("input not stalled with full queue");

  // a push into a full queue must coincide with a pop
  assert property (@(posedge clk) disable iff (rst)
    q_push && q_count == QCOUNT_BITS'(QUEUE_DEPTH) |-> q_pop)
    else $error("push into full queue");

  // the back end never pops an empty queue
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

@@ dv/selectable_weight_matvec_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selectable_weight_matvec_test
// Self-checking bench for the selectable-weight matrix-vector block.
// ----------------------------------------------------------------------------
// Items flow from a pending queue through a clocked driver. The driver keeps
// its own copy of both weight stores, the sample phase and the row
// accumulator. From these it works out each row sum as items are accepted.
// A clocked monitor checks every row result in order against those sums.
// The run has a short directed part, then random phases with several size
// settings. The idle rates change between some phases. One phase holds off the
// receiver for a long stretch, and one phase uses long rows.
module selectable_weight_matvec_test import smv_pkg::*;;

  localparam int VALUE_BITS = DEF_VALUE_BITS;
  localparam int MAX_COEFFS = DEF_MAX_COEFFS;
  localparam int MAX_ROWS   = DEF_MAX_ROWS;
  // mode with no meaning, must be ignored by the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // cycles to let pass once nothing is expected
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 120;

  typedef struct {
    logic [1:0]                   mode;
    logic [INDEX_BITS-1:0]        index;
    logic signed [VALUE_BITS-1:0] value;
    logic                         class_flag;
    logic                         batch_start;
  } item_t;

  typedef struct {
    logic signed [ACC_BITS-1:0] sum;
    logic                       last;
  } row_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic                         cfg_index = REG_COEFF_COUNT;
  logic [CFG_BITS-1:0]          cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   mode = MODE_LOAD_OTHER;
  logic [INDEX_BITS-1:0]        weight_index = '0;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         class_flag = 1'b0;
  logic                         batch_start = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [ACC_BITS-1:0]   row_sum;
  logic                         last_row;

  // stimulus and expected rows
  item_t       feed[$];
  row_result_t due_rows[$];
  int          send_idle_pct = 22;
  int          recv_idle_pct = 65;
  bit          long_hold_req = 1'b0;
  int          bad_count = 0;
  int          loaded = 0;

  // shadow of the block's state
  logic signed [VALUE_BITS-1:0] other_w [MAX_COEFFS];
  logic signed [VALUE_BITS-1:0] same_w [MAX_COEFFS];
  logic [ACC_BITS-1:0]          acc = '0;
  int unsigned                  col_pos = 0;
  int unsigned                  row_pos = 0;
  logic [1:0]                   sample_pos = 2'd0;
  bit                           pick_same = 1'b0;
  logic [CFG_BITS-1:0]          coeff_reg = COEFF_COUNT_RESET;
  logic [CFG_BITS-1:0]          row_reg = ROW_COUNT_RESET;

  selectable_weight_matvec u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .weight_index (weight_index),
    .value        (value),
    .class_flag   (class_flag),
    .batch_start  (batch_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_sum      (row_sum),
    .last_row     (last_row)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // zero acts as one, anything above the maximum saturates
  function automatic int unsigned effective_count(logic [CFG_BITS-1:0] c, int maxv);
    if (c == 0) return 1;
    return (c > maxv) ? maxv : c;
  endfunction

  // apply one accepted item, queue the row sum it completes
  function automatic void accumulate_item(item_t it);
    int unsigned                    ncoef;
    int unsigned                    nrows;
    int unsigned                    pos;
    logic signed [VALUE_BITS-1:0]   w;
    logic signed [2*VALUE_BITS-1:0] prod;
    logic                           final_row;
    row_result_t                    done;
    ncoef = effective_count(coeff_reg, MAX_COEFFS);
    nrows = effective_count(row_reg, MAX_ROWS);
    case (it.mode)
      MODE_LOAD_OTHER: other_w[it.index] = it.value;
      MODE_LOAD_SAME:  same_w[it.index] = it.value;
      MODE_FEATURE: begin
        // flags only count on the first feature of a sample
        if (col_pos == 0 && row_pos == 0) begin
          pos = it.batch_start ? 0 : sample_pos;
          pick_same = it.class_flag && (pos == SAME_PHASE);
          sample_pos = 2'((pos + 1) % 3);
        end
        w = pick_same ? same_w[col_pos] : other_w[col_pos];
        prod = it.value * w;
        acc = acc + {{(ACC_BITS - 2*VALUE_BITS){prod[2*VALUE_BITS-1]}}, prod};
        if (col_pos + 1 >= ncoef) begin
          final_row = (row_pos + 1 >= nrows);
          done.sum  = acc;
          done.last = final_row;
          due_rows.insert(due_rows.size(), done);
          acc = '0;
          col_pos = 0;
          row_pos = final_row ? 0 : row_pos + 1;
        end else begin
          col_pos++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] m, logic [INDEX_BITS-1:0] idx,
                                     logic signed [VALUE_BITS-1:0] v, logic cf, logic bs);
    item_t it;
    it.mode        = m;
    it.index       = idx;
    it.value       = v;
    it.class_flag  = cf;
    it.batch_start = bs;
    feed.insert(feed.size(), it);
  endfunction

  // mostly random, with the extremes now and then
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // fill both stores so that no feature reads an unwritten entry
  function automatic void load_weights(int upto);
    for (int i = loaded; i < upto; i++) begin
      queue_item(MODE_LOAD_OTHER, INDEX_BITS'(i), pick_value(), 1'b0, 1'b0);
      queue_item(MODE_LOAD_SAME, INDEX_BITS'(i), pick_value(), 1'b0, 1'b0);
    end
    if (upto > loaded) loaded = upto;
  endfunction

  // random feature streams with weight reloads and unused-mode noise
  function automatic void add_random_items(int n);
    int made;
    int r;
    logic [INDEX_BITS-1:0] idx;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        queue_item(MODE_UNUSED, INDEX_BITS'($urandom), pick_value(), 1'($urandom),
                   1'($urandom));
      end else begin
        if (r < 16) begin
          idx = $urandom_range(1) ? INDEX_BITS'($urandom_range(MAX_COEFFS - 1))
                                  : INDEX_BITS'($urandom_range(loaded - 1));
          queue_item(r[0] ? MODE_LOAD_SAME : MODE_LOAD_OTHER, idx, pick_value(),
                     1'($urandom), 1'($urandom));
        end else begin
          queue_item(MODE_FEATURE, INDEX_BITS'($urandom), pick_value(), 1'($urandom),
                     $urandom_range(7) == 0);
        end
        made++;
      end
    end
  endfunction

  // wait until every item is in and every row sum is out
  task automatic drain();
    while (feed.size() != 0 || in_valid || due_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_COEFF_COUNT) coeff_reg = data;
    else row_reg = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sizes(logic [CFG_BITS-1:0] coeffs, logic [CFG_BITS-1:0] rows);
    write_reg(REG_COEFF_COUNT, coeffs);
    write_reg(REG_ROW_COUNT, rows);
    @(negedge clk);
  endtask

  // driver: predicts each accepted item, then offers the next one
  always @(posedge clk) begin
    item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) accumulate_item('{mode, weight_index, value, class_flag, batch_start});
      if (feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = feed.pop_front();
        in_valid     <= 1'b1;
        mode         <= next_item.mode;
        weight_index <= next_item.index;
        value        <= next_item.value;
        class_flag   <= next_item.class_flag;
        batch_start  <= next_item.batch_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each accepted row result, drives the stall
  always @(posedge clk) begin
    row_result_t want;
    bit          hold_taken;
    int          hold_left;
    if (rst) begin
      out_stall  <= 1'b0;
      hold_taken = 1'b0;
      hold_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_rows.size() == 0) begin
          if (bad_count < 10) $display("unexpected row result: sum %0d last %0b",
                                       row_sum, last_row);
          bad_count++;
        end else begin
          want = due_rows.pop_front();
          if (row_sum !== want.sum || last_row !== want.last) begin
            if (bad_count < 10)
              $display("row mismatch: expected sum %0d last %0b, got sum %0d last %0b",
                       want.sum, want.last, row_sum, last_row);
            bad_count++;
          end
        end
      end
      // a single long hold-off when asked, random stalls otherwise
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // run limit
  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extreme values, both stores, sample positions and batch restart
    set_sizes(11'd2, 11'd2);
    queue_item(MODE_LOAD_OTHER, 10'd0, 16'h8000, 1'b0, 1'b0);
    queue_item(MODE_LOAD_OTHER, 10'd1, 16'h7FFF, 1'b0, 1'b0);
    queue_item(MODE_LOAD_SAME, 10'd0, 16'h7FFF, 1'b0, 1'b0);
    queue_item(MODE_LOAD_SAME, 10'd1, 16'h8000, 1'b0, 1'b0);
    queue_item(MODE_LOAD_OTHER, 10'h3FF, 16'hFFFF, 1'b1, 1'b1);
    queue_item(MODE_UNUSED, 10'h3FF, 16'h8000, 1'b1, 1'b1);
    loaded = 2;
    // first sample of a batch, class set but position 0, flags ignored mid-sample
    queue_item(MODE_FEATURE, 10'h3FF, 16'h8000, 1'b1, 1'b1);
    queue_item(MODE_FEATURE, 10'h000, 16'h8000, 1'b0, 1'b1);
    queue_item(MODE_FEATURE, 10'h000, 16'h7FFF, 1'b0, 1'b1);
    queue_item(MODE_FEATURE, 10'h000, 16'h7FFF, 1'b1, 1'b0);
    // position 1, other class
    queue_item(MODE_FEATURE, 10'h155, 16'h0000, 1'b0, 1'b0);
    queue_item(MODE_FEATURE, 10'h2AA, 16'hFFFF, 1'b1, 1'b1);
    queue_item(MODE_FEATURE, 10'h155, 16'h7FFF, 1'b1, 1'b0);
    queue_item(MODE_FEATURE, 10'h2AA, 16'h8000, 1'b0, 1'b1);
    // position 2 with class set: same-class weights
    queue_item(MODE_FEATURE, 10'h000, 16'h8000, 1'b1, 1'b0);
    queue_item(MODE_FEATURE, 10'h000, 16'h8000, 1'b0, 1'b0);
    queue_item(MODE_FEATURE, 10'h000, 16'h7FFF, 1'b0, 1'b0);
    queue_item(MODE_FEATURE, 10'h000, 16'h8000, 1'b0, 1'b0);
    // batch restart puts the position back to 0
    queue_item(MODE_FEATURE, 10'h000, pick_value(), 1'b1, 1'b1);
    queue_item(MODE_FEATURE, 10'h000, pick_value(), 1'b0, 1'b0);
    queue_item(MODE_FEATURE, 10'h000, pick_value(), 1'b0, 1'b0);
    queue_item(MODE_FEATURE, 10'h000, pick_value(), 1'b0, 1'b0);
    drain();

    // smallest sizes
    set_sizes(11'd1, 11'd1);
    add_random_items(250);
    drain();

    set_sizes(11'd5, 11'd3);
    load_weights(5);
    add_random_items(250);
    drain();

    // sender slow, receiver quick; a zero coefficient count acts as one
    send_idle_pct = 65;
    recv_idle_pct = 22;
    set_sizes(11'd0, 11'd7);
    add_random_items(250);
    drain();

    // row count above the maximum saturates
    set_sizes(11'd3, 11'h7FF);
    add_random_items(250);
    drain();

    // no idling; long receiver hold-off fills the block and stalls its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_sizes(11'd1, 11'd1024);
    long_hold_req = 1'b1;
    add_random_items(250);
    drain();

    // long rows, zero row count acts as one
    set_sizes(11'd40, 11'd0);
    load_weights(40);
    for (int i = 0; i < 160; i++)
      queue_item(MODE_FEATURE, INDEX_BITS'($urandom), pick_value(), 1'($urandom),
                 $urandom_range(7) == 0);
    drain();

    set_sizes(11'd7, 11'd4);
    add_random_items(250);
    drain();

    if (bad_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ selectable_weight_matvec.f @@
rtl/smv_pkg.sv
rtl/smv_ram.sv
rtl/smv_queue.sv
rtl/smv_front.sv
rtl/smv_back.sv
rtl/selectable_weight_matvec.sv
dv/selectable_weight_matvec_test.sv
